// ===== hdl/ivsq_pkg.sv =====
// shared types and constants for the inverse square root mod 2^k block
package ivsq_pkg;

    localparam int IO_W  = 64;
    localparam int CFG_W = 7;

    localparam logic [CFG_W-1:0] RING_BITS_RST = 7'd64;
    localparam logic [CFG_W-1:0] MIN_BITS      = 7'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_INV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic root_step;
        logic inv_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic min_k;
        logic last;
        logic next_last;
    } t_dp_status;

endpackage

// ===== hdl/ivsq_datapath.sv =====
// lifting datapath: root, square, product and inverse registers with shift-add updates
module ivsq_datapath
    import ivsq_pkg::*;
#(
    parameter int DATA_W = 64,
    parameter int KW     = 7
) (
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [KW-1:0]     i_k,
    input  logic [IO_W-1:0]   i_square_value,
    input  logic              i_batch_last_in,
    output logic [IO_W-1:0]   o_inv_sqrt,
    output logic              o_batch_last_out
);

    localparam logic [DATA_W-1:0] ONE      = {{(DATA_W-1){1'b0}}, 1'b1};
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    logic [DATA_W-1:0] r_e;
    logic [DATA_W-1:0] r_r;
    logic [DATA_W-1:0] r_sq;
    logic [DATA_W-1:0] r_p;
    logic [DATA_W-1:0] r_v;
    logic              r_b;
    logic [KW-1:0]     r_j;
    logic [KW-1:0]     r_k;
    logic              r_last;
    logic [DATA_W-1:0] r_out_val;
    logic              r_out_last;

    logic [DATA_W-1:0] oh_j;
    logic [DATA_W-1:0] root_term;
    logic [DATA_W-1:0] t_root;
    logic [DATA_W-1:0] t_root_sh;
    logic [DATA_W-1:0] t_inv;
    logic [DATA_W-1:0] t_inv_sh;
    logic [DATA_W-1:0] ld_t;
    logic [DATA_W-1:0] k_mask;
    logic [KW-1:0]     jp1;
    logic [KW-1:0]     jp2;
    logic              d_bit;

    assign jp1       = r_j + KW'(1);
    assign jp2       = r_j + KW'(2);
    assign oh_j      = ONE << r_j;
    assign root_term = (r_r << jp1) + (oh_j << r_j);
    assign t_root    = r_e - r_sq;
    assign t_root_sh = t_root >> jp2;
    assign t_inv     = ONE - r_p;
    assign t_inv_sh  = t_inv >> r_j;
    assign d_bit     = t_inv_sh[0];
    assign ld_t      = i_square_value[DATA_W-1:0] - ONE;
    assign k_mask    = ~(ALL_ONES << r_k);

    assign o_status.min_k     = (i_k == KW'(3));
    assign o_status.last      = (jp1 == r_k);
    assign o_status.next_last = (jp2 == r_k);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e    <= i_square_value[DATA_W-1:0];
            r_r    <= ONE;
            r_sq   <= ONE;
            r_p    <= ONE;
            r_v    <= ONE;
            r_b    <= ld_t[3];
            r_j    <= KW'(2);
            r_k    <= i_k;
            r_last <= i_batch_last_in;
        end else if (i_cmd.root_step) begin
            if (r_b) begin
                r_r  <= r_r | oh_j;
                r_sq <= r_sq + root_term;
                r_p  <= r_p + (r_v << r_j);
            end
        end else if (i_cmd.inv_step) begin
            if (d_bit) begin
                r_v <= r_v | oh_j;
                r_p <= r_p + (r_r << r_j);
            end
            r_b <= t_root_sh[0];
            r_j <= jp1;
        end
        if (i_cmd.out_load) begin
            r_out_val  <= r_v & k_mask;
            r_out_last <= r_last;
        end
    end

    assign o_inv_sqrt       = IO_W'(r_out_val);
    assign o_batch_last_out = r_out_last;

endmodule

// ===== hdl/ivsq_ctrl.sv =====
// sequencer: steps the root and inverse bit updates and owns the item handshakes
module ivsq_ctrl
    import ivsq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.min_k ? S_INV : S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_state         = S_INV;
            end
            S_INV: begin
                o_cmd.inv_step = 1'b1;
                if (i_status.last) begin
                    n_state = S_DONE;
                end else if (i_status.next_last) begin
                    n_state = S_INV;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/inverse_square_root_mod_power_of_two_top.sv =====
// top level: inverse square root mod 2^k by bit-serial lifting
// the root and inverse shift-add steps share one datapath, so a new item is accepted
// only once the last one has left the sequencer
// the finished result waits in an output register while the next item is worked on
// reset: synchronous active low, clears the sequencer and sets ring_bits to 64
module inverse_square_root_mod_power_of_two_top
    import ivsq_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_ring_bits,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [IO_W-1:0]   i_square_value,
    input  logic              i_batch_last_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IO_W-1:0]   o_inv_sqrt,
    output logic              o_batch_last_out
);

    localparam int DATA_W = (WORD_BITS < IO_W) ? WORD_BITS : IO_W;
    localparam int KW     = $clog2(DATA_W + 2);

    localparam logic [CFG_W-1:0] MAX_BITS = CFG_W'(DATA_W);

    logic [CFG_W-1:0] r_ring_bits;
    logic [CFG_W-1:0] k_clamped;
    t_dp_cmd          cmd;
    t_dp_status       status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_bits <= RING_BITS_RST;
        end else if (i_cfg_we) begin
            r_ring_bits <= i_cfg_ring_bits;
        end
    end

    // clamp k to the supported range
    always_comb begin
        if (r_ring_bits < MIN_BITS) begin
            k_clamped = MIN_BITS;
        end else if (r_ring_bits > MAX_BITS) begin
            k_clamped = MAX_BITS;
        end else begin
            k_clamped = r_ring_bits;
        end
    end

    ivsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ivsq_datapath #(
        .DATA_W (DATA_W),
        .KW     (KW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_k              (KW'(k_clamped)),
        .i_square_value   (i_square_value),
        .i_batch_last_in  (i_batch_last_in),
        .o_inv_sqrt       (o_inv_sqrt),
        .o_batch_last_out (o_batch_last_out)
    );

endmodule

// ===== hdl/ivsq_checker.sv =====
// port-level checks for the inverse square root block, bound to the top level
module ivsq_checker
    import ivsq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [IO_W-1:0]  o_inv_sqrt,
    input logic             o_batch_last_out
);

    // one item in the sequencer at a time: no new item right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an item was accepted");

    // no result can appear the cycle after an item is accepted
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared too soon after acceptance");

    // lifted inverse always has bit 0 set and bit 1 clear
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_inv_sqrt[0] && !o_inv_sqrt[1]))
        else $error("result low bits are not 01");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_inv_sqrt) && $stable(o_batch_last_out)))
        else $error("stalled result changed");

endmodule

bind inverse_square_root_mod_power_of_two_top ivsq_checker u_ivsq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_inv_sqrt       (o_inv_sqrt),
    .o_batch_last_out (o_batch_last_out)
);
